// ----- rtl/aetok_pkg.sv -----
// Package for the arithmetic expression tokenizer.
// Holds byte classes, token tags, character codes and the beat types that
// pass between the front, the back and the result queue. No dependencies.
`timescale 1ns / 1ps

package aetok_pkg;

  // Longest text that offsets and lengths track before they saturate.
  localparam int MAX_TEXT = 4096;

  // Field widths of the result beat.
  localparam int CH_W  = 8;
  localparam int TAG_W = 4;
  localparam int OFF_W = 12;
  localparam int LEN_W = 13;

  // Internal counters must hold MAX_TEXT itself.
  localparam int POS_W = $clog2(MAX_TEXT + 1);

  // Token tags.
  localparam logic [TAG_W-1:0] TAG_EOF     = 4'd0;
  localparam logic [TAG_W-1:0] TAG_IDENT   = 4'd1;
  localparam logic [TAG_W-1:0] TAG_GIVEN   = 4'd2;
  localparam logic [TAG_W-1:0] TAG_NUMBER  = 4'd3;
  localparam logic [TAG_W-1:0] TAG_PLUS    = 4'd4;
  localparam logic [TAG_W-1:0] TAG_MINUS   = 4'd5;
  localparam logic [TAG_W-1:0] TAG_STAR    = 4'd6;
  localparam logic [TAG_W-1:0] TAG_SLASH   = 4'd7;
  localparam logic [TAG_W-1:0] TAG_LPAREN  = 4'd8;
  localparam logic [TAG_W-1:0] TAG_RPAREN  = 4'd9;
  localparam logic [TAG_W-1:0] TAG_COLON   = 4'd10;
  localparam logic [TAG_W-1:0] TAG_COMMA   = 4'd11;
  localparam logic [TAG_W-1:0] TAG_UNKNOWN = 4'd12;

  // Character codes.
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_DIG_LO = 8'h30;
  localparam logic [CH_W-1:0] CH_DIG_HI = 8'h39;
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CH_W-1:0] CH_UC_LO  = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_HI  = 8'h5A;
  localparam logic [CH_W-1:0] CH_LC_LO  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_HI  = 8'h7A;

  // Keyword length and the keyword progress width.
  localparam int KW_LEN = 5;
  localparam int KW_W   = 3;

  // Byte classes decided by the front.
  typedef enum logic [2:0] {
    CLS_END,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SPACE,
    CLS_SINGLE
  } cls_e;

  // Classified input beat.
  typedef struct packed {
    cls_e             cls;
    logic [TAG_W-1:0] single_tag;
    logic [CH_W-1:0]  ch;
  } cls_item_t;

  // Result beat.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [OFF_W-1:0] start_offset;
    logic [LEN_W-1:0] length;
    logic             overflow;
    logic             last;
  } token_t;

  // Letters of the keyword "given".
  function automatic logic [CH_W-1:0] kw_char(input logic [KW_W-1:0] idx);
    logic [CH_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h67;
      3'd1:    c = 8'h69;
      3'd2:    c = 8'h76;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h6E;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/aetok_front.sv -----
// Front of the tokenizer: classifies each input byte and holds the
// classified beats in a two-entry queue for the back. Uses aetok_pkg.
`timescale 1ns / 1ps

module aetok_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [aetok_pkg::CH_W-1:0] ch_i,
  output logic                      item_valid_o,
  output aetok_pkg::cls_item_t      item_o,
  input  logic                      item_take_i
);
  import aetok_pkg::*;

  cls_item_t   cls_item;
  cls_item_t   mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        wr_en;
  logic        rd_en;

  // Byte classification and one-byte token tags.
  always_comb begin
    cls_item.ch         = ch_i;
    cls_item.single_tag = TAG_UNKNOWN;
    cls_item.cls        = CLS_SINGLE;
    if (ch_i == CH_NUL) begin
      cls_item.cls = CLS_END;
    end else if ((ch_i >= CH_LC_LO && ch_i <= CH_LC_HI) ||
                 (ch_i >= CH_UC_LO && ch_i <= CH_UC_HI)) begin
      cls_item.cls = CLS_LETTER;
    end else if (ch_i >= CH_DIG_LO && ch_i <= CH_DIG_HI) begin
      cls_item.cls = CLS_DIGIT;
    end else if (ch_i == CH_SPACE || ch_i == CH_TAB || ch_i == CH_FF ||
                 ch_i == CH_VT || ch_i == CH_CR || ch_i == CH_LF) begin
      cls_item.cls = CLS_SPACE;
    end
    unique case (ch_i)
      CH_PLUS:   cls_item.single_tag = TAG_PLUS;
      CH_MINUS:  cls_item.single_tag = TAG_MINUS;
      CH_STAR:   cls_item.single_tag = TAG_STAR;
      CH_SLASH:  cls_item.single_tag = TAG_SLASH;
      CH_LPAREN: cls_item.single_tag = TAG_LPAREN;
      CH_RPAREN: cls_item.single_tag = TAG_RPAREN;
      CH_COLON:  cls_item.single_tag = TAG_COLON;
      CH_COMMA:  cls_item.single_tag = TAG_COMMA;
      default:   cls_item.single_tag = TAG_UNKNOWN;
    endcase
  end

  // Queue control.
  assign full         = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    count_d  = count_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

// ----- rtl/aetok_tok_fifo.sv -----
// Result queue of the tokenizer: four entries, up to two writes and one
// read per cycle. Uses aetok_pkg for the token beat type.
`timescale 1ns / 1ps

module aetok_tok_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we0_i,
  input  aetok_pkg::token_t  wdata0_i,
  input  logic               we1_i,
  input  aetok_pkg::token_t  wdata1_i,
  output logic               room2_o,
  output logic               empty,
  input  logic               pop,
  output aetok_pkg::token_t  rdata_o
);
  import aetok_pkg::*;

  token_t      mem_q [4];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [2:0]  count_q, count_d;
  logic [1:0]  n_wr;
  logic        rd_en;

  // Two free entries are needed before the back may retire a byte.
  assign room2_o = (count_q <= 3'd2);
  assign empty   = (count_q == 3'd0);
  assign rd_en   = pop && !empty;
  assign rdata_o = mem_q[rd_ptr_q];
  assign n_wr    = {1'b0, we0_i} + {1'b0, we1_i};

  always_comb begin
    wr_ptr_d = wr_ptr_q + n_wr;
    rd_ptr_d = rd_ptr_q + {1'b0, rd_en};
    count_d  = count_q + {1'b0, n_wr} - {2'b00, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // The second write is only used together with the first.
  always_ff @(posedge clk_i) begin
    if (we0_i) begin
      mem_q[wr_ptr_q] <= wdata0_i;
    end
    if (we1_i) begin
      mem_q[wr_ptr_q + 2'd1] <= wdata1_i;
    end
  end

endmodule

// ----- rtl/aetok_back.sv -----
// Back of the tokenizer: keeps the run state and position, turns each
// classified beat into zero, one or two tokens. Uses aetok_pkg.
`timescale 1ns / 1ps

module aetok_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  aetok_pkg::cls_item_t item_i,
  output logic                 item_take_o,
  input  logic                 room2_i,
  output logic                 we0_o,
  output aetok_pkg::token_t    tok0_o,
  output logic                 we1_o,
  output aetok_pkg::token_t    tok1_o
);
  import aetok_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  logic [1:0]       mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [OFF_W-1:0] start_q, start_d;
  logic [POS_W-1:0] len_q, len_d;
  logic [KW_W-1:0]  kw_q, kw_d;
  logic             miss_q, miss_d;
  logic             sat_q, sat_d;

  logic             pos_full;
  logic             len_full;
  logic [OFF_W-1:0] cur_off;
  logic [POS_W-1:0] pos_adv;
  logic             sat_adv;
  logic             kw_hit;
  logic             kw_first;
  token_t           run_tok;
  token_t           eof_tok;
  token_t           one_tok;

  assign item_take_o = item_valid_i && room2_i;

  // Offset of this byte, clamped, and the position after taking it.
  assign pos_full = (pos_q >= POS_W'(MAX_TEXT));
  assign cur_off  = pos_full ? OFF_W'(MAX_TEXT - 1) : pos_q[OFF_W-1:0];
  assign pos_adv  = pos_full ? pos_q : pos_q + POS_W'(1);
  assign sat_adv  = sat_q | pos_full;
  assign len_full = (len_q >= POS_W'(MAX_TEXT));

  // Keyword match against the next expected letter.
  assign kw_hit   = !miss_q && (kw_q < KW_W'(KW_LEN)) && (item_i.ch == kw_char(kw_q));
  assign kw_first = (item_i.ch == kw_char(KW_W'(0)));

  // Candidate tokens.
  always_comb begin
    run_tok.tag          = (mode_q == MODE_NUMBER) ? TAG_NUMBER :
                           (!miss_q && kw_q == KW_W'(KW_LEN)) ? TAG_GIVEN : TAG_IDENT;
    run_tok.start_offset = start_q;
    run_tok.length       = LEN_W'(len_q);
    run_tok.overflow     = sat_q;
    run_tok.last         = 1'b0;

    eof_tok.tag          = TAG_EOF;
    eof_tok.start_offset = cur_off;
    eof_tok.length       = '0;
    eof_tok.overflow     = sat_q;
    eof_tok.last         = 1'b1;

    one_tok.tag          = item_i.single_tag;
    one_tok.start_offset = cur_off;
    one_tok.length       = LEN_W'(1);
    one_tok.overflow     = sat_adv;
    one_tok.last         = 1'b1;
  end

  // Run state update and token selection for one beat.
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    kw_d    = kw_q;
    miss_d  = miss_q;
    sat_d   = sat_q;
    we0_o   = 1'b0;
    we1_o   = 1'b0;
    tok0_o  = run_tok;
    tok1_o  = one_tok;

    if (item_take_o) begin
      if (item_i.cls == CLS_END) begin
        // Flush any run, then eof; everything returns to reset values.
        we0_o = 1'b1;
        if (mode_q != MODE_IDLE) begin
          we1_o  = 1'b1;
          tok1_o = eof_tok;
        end else begin
          tok0_o = eof_tok;
        end
        mode_d  = MODE_IDLE;
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
        kw_d    = '0;
        miss_d  = 1'b0;
        sat_d   = 1'b0;
      end else if ((mode_q == MODE_IDENT && item_i.cls == CLS_LETTER) ||
                   (mode_q == MODE_NUMBER && item_i.cls == CLS_DIGIT)) begin
        // The byte extends the current run.
        pos_d = pos_adv;
        if (len_full) begin
          sat_d = 1'b1;
        end else begin
          len_d = len_q + POS_W'(1);
          sat_d = sat_adv;
        end
        if (mode_q == MODE_IDENT) begin
          if (kw_hit) begin
            kw_d = kw_q + KW_W'(1);
          end else begin
            miss_d = 1'b1;
          end
        end
      end else begin
        // The byte closes any run and is taken on its own.
        pos_d  = pos_adv;
        sat_d  = sat_adv;
        mode_d = MODE_IDLE;
        len_d  = '0;
        kw_d   = '0;
        miss_d = 1'b0;
        if (item_i.cls == CLS_LETTER) begin
          mode_d  = MODE_IDENT;
          start_d = cur_off;
          len_d   = POS_W'(1);
          kw_d    = kw_first ? KW_W'(1) : KW_W'(0);
          miss_d  = !kw_first;
        end else if (item_i.cls == CLS_DIGIT) begin
          mode_d  = MODE_NUMBER;
          start_d = cur_off;
          len_d   = POS_W'(1);
        end
        if (mode_q != MODE_IDLE) begin
          we0_o = 1'b1;
          if (item_i.cls == CLS_SINGLE) begin
            we1_o = 1'b1;
          end else begin
            tok0_o.last = 1'b1;
          end
        end else if (item_i.cls == CLS_SINGLE) begin
          we0_o  = 1'b1;
          tok0_o = one_tok;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      kw_q    <= '0;
      miss_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
      miss_q  <= miss_d;
      sat_q   <= sat_d;
    end
  end

endmodule

// ----- rtl/arith_expression_tokenizer_unit.sv -----
// Top level of the arithmetic expression tokenizer.
// Instantiates aetok_front, aetok_back and aetok_tok_fifo; uses aetok_pkg.
//
//   Channel   Handshake           Payload
//   input     push / full         ch_i
//   result    empty / pop         tag_o start_offset_o length_o overflow_o last_o
//
// One byte is retired per cycle by the back while the result queue has room. A
// byte passes the front queue, and its tokens the result queue, before they reach
// the result ports. Each byte yields up to two result beats, and one result beat
// leaves per cycle while pop is high and the result queue is not empty.
// The back retires a byte only when the result queue has two free entries, so a
// stalled result side fills the result queue and then the front queue.
// Reset clears the run state, the position and both queues.
`timescale 1ns / 1ps

module arith_expression_tokenizer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [aetok_pkg::CH_W-1:0]  ch_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [aetok_pkg::TAG_W-1:0] tag_o,
  output logic [aetok_pkg::OFF_W-1:0] start_offset_o,
  output logic [aetok_pkg::LEN_W-1:0] length_o,
  output logic                        overflow_o,
  output logic                        last_o
);
  import aetok_pkg::*;

  logic      item_valid;
  cls_item_t item;
  logic      item_take;
  logic      room2;
  logic      we0;
  logic      we1;
  token_t    tok0;
  token_t    tok1;
  token_t    rdata;

  // Classifier and input queue.
  aetok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .ch_i         (ch_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Run tracking and token generation.
  aetok_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .room2_i      (room2),
    .we0_o        (we0),
    .tok0_o       (tok0),
    .we1_o        (we1),
    .tok1_o       (tok1)
  );

  // Result queue.
  aetok_tok_fifo u_tok_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we0_i    (we0),
    .wdata0_i (tok0),
    .we1_i    (we1),
    .wdata1_i (tok1),
    .room2_o  (room2),
    .empty    (empty),
    .pop      (pop),
    .rdata_o  (rdata)
  );

  assign tag_o          = rdata.tag;
  assign start_offset_o = rdata.start_offset;
  assign length_o       = rdata.length;
  assign overflow_o     = rdata.overflow;
  assign last_o         = rdata.last;

endmodule
